[rtl/mme_pkg.sv]
package mme_pkg;

	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned PROD_W  = 32;
	localparam int unsigned ACC_W   = 35;
	localparam int unsigned DIM_W   = 4;
	localparam int unsigned CFG_IW  = 2;

	localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

	localparam logic [CFG_IW-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IW-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IW-1:0] REG_COLS_B    = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	// Control that travels with each multiply-accumulate step.
	typedef struct packed {
		logic             first_k;
		logic             last_k;
		logic             last_elem;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tag_t;

endpackage

[rtl/mme_mac.sv]
module mme_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step_valid,
	input  mme_pkg::tag_t                      step_tag,
	input  logic signed [mme_pkg::DATA_W-1:0]  a_data,
	input  logic signed [mme_pkg::DATA_W-1:0]  b_data,
	output logic                               res_valid,
	output mme_pkg::tag_t                      res_tag,
	output logic signed [mme_pkg::ACC_W-1:0]   res_value
);
	import mme_pkg::*;

	logic                      valid_s2;
	tag_t                      tag_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= step_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2  <= step_tag;
		prod_s2 <= a_data * b_data;
	end

	assign prod_ext = ACC_W'(prod_s2);
	assign sum      = tag_s2.first_k ? prod_ext : acc_q + prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= sum;
		end
	end

	assign res_valid = valid_s2;
	assign res_tag   = tag_s2;
	assign res_value = sum;

endmodule

[rtl/matrix_multiply_engine.sv]
// Channel   Direction  Signals                                     Transaction
// in        sink       in_valid/in_ready, func row col value      one element write or compute
// out       source     out_valid/out_ready, out_row out_col       one result element or error
//                      out_value status last
// cfg       sink       cfg_we, cfg_index, cfg_data                 one register write, no wait
//
// A write out of bounds also loads the output register. A compute item holds intake for the
// rows_a * cols_b elements of the clamped dimensions: one multiplier and one read port per
// store serve the inner_dim steps of an element, then the read register and the product
// register drain before the sum is registered.
// Intake is closed for the compute run and while a result waits in the output register, and
// an element's first step waits for that register too. Reset clears control and valid bits.
module matrix_multiply_engine #(
	parameter int unsigned MAX_DIM = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [mme_pkg::FUNC_W-1:0]            func,
	input  logic [mme_pkg::IDX_W-1:0]             row,
	input  logic [mme_pkg::IDX_W-1:0]             col,
	input  logic signed [mme_pkg::DATA_W-1:0]     value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mme_pkg::IDX_W-1:0]             out_row,
	output logic [mme_pkg::IDX_W-1:0]             out_col,
	output logic signed [mme_pkg::ACC_W-1:0]      out_value,
	output logic                                  status,
	output logic                                  last,
	input  logic                                  cfg_we,
	input  logic [mme_pkg::CFG_IW-1:0]            cfg_index,
	input  logic [mme_pkg::DIM_W-1:0]             cfg_data
);
	import mme_pkg::*;

	localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_d;

	logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [DIM_W-1:0] m_eff, k_eff, n_eff;

	logic [IDX_W-1:0] i_q, j_q, k_q;

	logic signed [DATA_W-1:0] a_mem [DEPTH];
	logic signed [DATA_W-1:0] b_mem [DEPTH];
	logic [DEPTH-1:0]         a_valid_q, b_valid_q;

	logic                     in_acc, out_free, issue_valid, last_k, last_elem, done_elem;
	logic                     wr_a, wr_b, wr_err;
	logic [DIM_W-1:0]         rlim, clim;
	logic [6:0]               wr_addr7, a_addr7, b_addr7;
	logic [AW-1:0]            wr_addr, a_addr, b_addr;

	logic                     step_valid_s1;
	tag_t                     step_tag_s1, issue_tag;
	logic signed [DATA_W-1:0] a_rd_s1, b_rd_s1, a_op, b_op;
	logic                     a_vld_s1, b_vld_s1;

	logic                     res_valid;
	tag_t                     res_tag;
	logic signed [ACC_W-1:0]  res_value;

	logic                     out_valid_q, status_q, last_q;
	logic [IDX_W-1:0]         out_row_q, out_col_q;
	logic signed [ACC_W-1:0]  out_value_q;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		if (d == '0) begin
			return DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return d;
	endfunction

	assign m_eff = clamp_dim(rows_a_q);
	assign k_eff = clamp_dim(inner_dim_q);
	assign n_eff = clamp_dim(cols_b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Element writes.
	assign out_free = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign rlim     = (func == FUNC_WR_A) ? m_eff : k_eff;
	assign clim     = (func == FUNC_WR_A) ? k_eff : n_eff;
	assign wr_err   = (func == FUNC_WR_A || func == FUNC_WR_B) &&
			  ({1'b0, row} >= rlim || {1'b0, col} >= clim);
	assign wr_a     = in_acc && func == FUNC_WR_A && !wr_err;
	assign wr_b     = in_acc && func == FUNC_WR_B && !wr_err;
	assign wr_addr7 = 7'(row) * 7'(MAX_DIM) + 7'(col);
	assign wr_addr  = wr_addr7[AW-1:0];

	// Read addresses for the current step: A[i][k] and B[k][j].
	assign a_addr7 = 7'(i_q) * 7'(MAX_DIM) + 7'(k_q);
	assign b_addr7 = 7'(k_q) * 7'(MAX_DIM) + 7'(j_q);
	assign a_addr  = a_addr7[AW-1:0];
	assign b_addr  = b_addr7[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_a) begin
			a_mem[wr_addr] <= value;
		end
		if (wr_b) begin
			b_mem[wr_addr] <= value;
		end
		a_rd_s1 <= a_mem[a_addr];
		b_rd_s1 <= b_mem[b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= '0;
			b_valid_q <= '0;
			a_vld_s1  <= 1'b0;
			b_vld_s1  <= 1'b0;
		end else begin
			if (wr_a) begin
				a_valid_q[wr_addr] <= 1'b1;
			end
			if (wr_b) begin
				b_valid_q[wr_addr] <= 1'b1;
			end
			a_vld_s1 <= a_valid_q[a_addr];
			b_vld_s1 <= b_valid_q[b_addr];
		end
	end

	// An entry never written reads as zero.
	assign a_op = a_vld_s1 ? a_rd_s1 : '0;
	assign b_op = b_vld_s1 ? b_rd_s1 : '0;

	// Sequencer.
	assign last_k    = ({1'b0, k_q} + DIM_W'(1)) == k_eff;
	assign last_elem = ({1'b0, i_q} + DIM_W'(1)) == m_eff &&
			   ({1'b0, j_q} + DIM_W'(1)) == n_eff;
	assign done_elem = res_valid && res_tag.last_k;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && func == FUNC_COMPUTE) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (issue_valid && last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (done_elem) begin
					state_d = last_elem ? ST_IDLE : ST_ISSUE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// A new element starts only once the output register is free, so its
	// result can never overwrite one still waiting.
	always_comb begin
		in_ready    = 1'b0;
		issue_valid = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready    = out_free;
			ST_ISSUE: issue_valid = (k_q != '0) || out_free;
			ST_DRAIN: ;
			default:  ;
		endcase
	end

	assign issue_tag.first_k   = (k_q == '0);
	assign issue_tag.last_k    = last_k;
	assign issue_tag.last_elem = last_elem;
	assign issue_tag.row       = i_q;
	assign issue_tag.col       = j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			i_q           <= '0;
			j_q           <= '0;
			k_q           <= '0;
			step_valid_s1 <= 1'b0;
		end else begin
			state_q       <= state_d;
			step_valid_s1 <= issue_valid;
			if (state_q == ST_IDLE) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (issue_valid) begin
				k_q <= last_k ? '0 : k_q + IDX_W'(1);
			end else if (state_q == ST_DRAIN && done_elem && !last_elem) begin
				if (({1'b0, j_q} + DIM_W'(1)) == n_eff) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		step_tag_s1 <= issue_tag;
	end

	mme_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (step_valid_s1),
		.step_tag   (step_tag_s1),
		.a_data     (a_op),
		.b_data     (b_op),
		.res_valid  (res_valid),
		.res_tag    (res_tag),
		.res_value  (res_value)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_elem || (in_acc && wr_err)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_elem) begin
			out_row_q   <= res_tag.row;
			out_col_q   <= res_tag.col;
			out_value_q <= res_value;
			status_q    <= 1'b0;
			last_q      <= res_tag.last_elem;
		end else if (in_acc && wr_err) begin
			out_row_q   <= row;
			out_col_q   <= col;
			out_value_q <= '0;
			status_q    <= 1'b1;
			last_q      <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done_elem |-> (!out_valid_q || out_ready))
		else $error("result element arrived while the output register was held");

	a_compute_closes_intake: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && func == FUNC_COMPUTE) |=> !in_ready)
		else $error("intake stayed open after a compute transaction");

	a_error_result_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (!last && out_value == '0))
		else $error("error result carries a value or a last mark");

	a_issue_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issue_valid |-> !in_ready)
		else $error("step issued while intake was open");
`endif

endmodule

[sim/matrix_multiply_engine_tb.sv]
`timescale 1ns / 100ps

module matrix_multiply_engine_tb;
	import mme_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned TAIL_CYCLES = 32;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned PHASE_ITEMS = 31;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [DATA_W-1:0] value;
	} mm_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_col;
		logic signed [ACC_W-1:0] out_value;
		logic                    status;
		logic                    last;
	} mm_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [FUNC_W-1:0]        func = '0;
	logic [IDX_W-1:0]         row = '0;
	logic [IDX_W-1:0]         col = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [ACC_W-1:0]  out_value;
	logic                     status;
	logic                     last;
	logic                     cfg_we = 1'b0;
	logic [CFG_IW-1:0]        cfg_index = '0;
	logic [DIM_W-1:0]         cfg_data = '0;

	// Predictor state: element stores and dimension registers as last written.
	logic signed [DATA_W-1:0] a_mem [64];
	logic signed [DATA_W-1:0] b_mem [64];
	logic [DIM_W-1:0]         dim_rows = DIM_RESET;
	logic [DIM_W-1:0]         dim_inner = DIM_RESET;
	logic [DIM_W-1:0]         dim_cols = DIM_RESET;

	mm_item_t   pending_items[$];
	mm_result_t expected_elements[$];
	mm_item_t   offered_item;
	mm_result_t want;

	int unsigned error_count = 0;
	int unsigned stall_cycles = 0;
	bit          quiet_tail = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned hold_seen = 0;
	int unsigned tx_gap_left = 0;
	int unsigned tx_rate = 0;
	int unsigned tx_cycle = 0;
	int unsigned rx_hold_left = 0;
	int unsigned rx_stall_left = 0;
	int unsigned rx_rate = 0;
	int unsigned rx_cycle = 0;
	logic        rx_next;

	matrix_multiply_engine #(
		.MAX_DIM(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.row(row),
		.col(col),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_row(out_row),
		.out_col(out_col),
		.out_value(out_value),
		.status(status),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > 8)
			return 8;
		return d;
	endfunction

	function automatic int unsigned pick_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 35;
		endcase
	endfunction

	task automatic gemm_predict(input mm_item_t it);
		int unsigned m;
		int unsigned k;
		int unsigned n;
		int unsigned rlim;
		int unsigned clim;
		longint      acc;
		mm_result_t  res;
		m = clamp_dim(dim_rows);
		k = clamp_dim(dim_inner);
		n = clamp_dim(dim_cols);
		case (it.func)
			FUNC_WR_A, FUNC_WR_B: begin
				rlim = (it.func == FUNC_WR_A) ? m : k;
				clim = (it.func == FUNC_WR_A) ? k : n;
				if (it.row >= rlim || it.col >= clim) begin
					res = '{out_row: it.row, out_col: it.col, out_value: '0,
						status: 1'b1, last: 1'b0};
					expected_elements.push_back(res);
				end else if (it.func == FUNC_WR_A) begin
					a_mem[it.row * 8 + it.col] = it.value;
				end else begin
					b_mem[it.row * 8 + it.col] = it.value;
				end
			end
			FUNC_COMPUTE: begin
				for (int i = 0; i < m; i++) begin
					for (int j = 0; j < n; j++) begin
						acc = 0;
						for (int kk = 0; kk < k; kk++)
							acc += longint'(a_mem[i * 8 + kk]) * longint'(b_mem[kk * 8 + j]);
						res.out_row = IDX_W'(i);
						res.out_col = IDX_W'(j);
						res.out_value = acc[ACC_W-1:0];
						res.status = 1'b0;
						res.last = (i == m - 1 && j == n - 1);
						expected_elements.push_back(res);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// Sender: offers queued items, with random gaps between transactions.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				gemm_predict(offered_item);
			tx_cycle++;
			if (tx_cycle % 300 == 0)
				tx_rate = pick_rate();
			if (!in_valid || in_ready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					offered_item = pending_items.pop_front();
					in_valid <= 1'b1;
					func <= offered_item.func;
					row <= offered_item.row;
					col <= offered_item.col;
					value <= offered_item.value;
					if (!quiet_tail && $urandom_range(0, 99) < tx_rate)
						tx_gap_left = $urandom_range(1, 18);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall bursts plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 300 == 0)
				rx_rate = pick_rate();
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				rx_hold_left = LONG_HOLD;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				rx_next = 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				rx_next = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 99) < rx_rate) begin
				rx_stall_left = $urandom_range(0, 17);
				rx_next = 1'b0;
			end else begin
				rx_next = 1'b1;
			end
			out_ready <= rx_next;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_elements.size() == 0) begin
				$error("result with nothing outstanding: out_row %0d out_col %0d out_value %0d",
					out_row, out_col, out_value);
				error_count++;
			end else begin
				want = expected_elements.pop_front();
				if (out_row !== want.out_row) begin
					$error("out_row expected %0d actual %0d", want.out_row, out_row);
					error_count++;
				end
				if (out_col !== want.out_col) begin
					$error("out_col expected %0d actual %0d", want.out_col, out_col);
					error_count++;
				end
				if (out_value !== want.out_value) begin
					$error("out_value expected %0d actual %0d", want.out_value, out_value);
					error_count++;
				end
				if (status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, status);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last expected %0d actual %0d", want.last, last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (arst_n);
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("matrix_multiply_engine_tb: errors");
		$finish;
	end

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		if ($urandom_range(0, 4) == 0)
			return DIM_W'($urandom_range(0, 15));
		return DIM_W'($urandom_range(1, 4));
	endfunction

	task automatic push_item(input logic [FUNC_W-1:0] f, input int unsigned r,
		input int unsigned c, input logic signed [DATA_W-1:0] v);
		pending_items.push_back('{func: f, row: IDX_W'(r), col: IDX_W'(c), value: v});
	endtask

	// Mostly in-bounds writes so that computes see real data; the rest are
	// writes at any index, unused codes and extra computes.
	task automatic queue_random_items(input int unsigned count);
		int unsigned m;
		int unsigned k;
		int unsigned n;
		int unsigned roll;
		m = clamp_dim(dim_rows);
		k = clamp_dim(dim_inner);
		n = clamp_dim(dim_cols);
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 38)
				push_item(FUNC_WR_A, $urandom_range(0, m - 1), $urandom_range(0, k - 1),
					rand_value());
			else if (roll < 76)
				push_item(FUNC_WR_B, $urandom_range(0, k - 1), $urandom_range(0, n - 1),
					rand_value());
			else if (roll < 90)
				push_item($urandom_range(0, 1) ? FUNC_WR_B : FUNC_WR_A, $urandom_range(0, 7),
					$urandom_range(0, 7), rand_value());
			else if (roll < 94)
				push_item(FUNC_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
					rand_value());
			else
				push_item(FUNC_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
					rand_value());
		end
		push_item(FUNC_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
	endtask

	task automatic drain_all();
		@(posedge clk);
		while (pending_items.size() != 0 || in_valid || expected_elements.size() != 0)
			@(posedge clk);
	endtask

	// The block must be idle here; the predictor copy follows the write.
	task automatic write_dims(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] k,
		input logic [DIM_W-1:0] n);
		drain_all();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS_A;
		cfg_data <= m;
		dim_rows = m;
		@(posedge clk);
		cfg_index <= REG_INNER_DIM;
		cfg_data <= k;
		dim_inner = k;
		@(posedge clk);
		cfg_index <= REG_COLS_B;
		cfg_data <= n;
		dim_cols = n;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		foreach (a_mem[i]) begin
			a_mem[i] = '0;
			b_mem[i] = '0;
		end
		tx_rate = pick_rate();
		rx_rate = pick_rate();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Full-scale operands: row 7 of A against column 7 of B reaches the
		// largest positive sum, and the corners mix both extremes.
		for (int i = 0; i < 8; i++) begin
			push_item(FUNC_WR_A, 7, i, 16'sh8000);
			push_item(FUNC_WR_B, i, 7, 16'sh8000);
		end
		push_item(FUNC_WR_A, 0, 0, 16'sh7fff);
		push_item(FUNC_WR_B, 0, 0, 16'sh7fff);
		push_item(FUNC_COMPUTE, 7, 7, 16'sh7fff);

		// Out-of-bounds writes on each index of both stores, an unused code.
		write_dims(4'd2, 4'd3, 4'd2);
		push_item(FUNC_WR_A, 2, 0, 16'sh1234);
		push_item(FUNC_WR_A, 0, 3, 16'sh1234);
		push_item(FUNC_WR_B, 3, 0, 16'sh1234);
		push_item(FUNC_WR_B, 0, 2, 16'sh1234);
		push_item(FUNC_WR_B, 2, 1, 16'sh7fff);
		push_item(FUNC_UNUSED, 7, 7, -16'sd1);
		push_item(FUNC_COMPUTE, 0, 0, '0);

		write_dims(4'd1, 4'd1, 4'd1);
		queue_random_items(PHASE_ITEMS);

		write_dims(4'd8, 4'd8, 4'd8);
		queue_random_items(PHASE_ITEMS);

		// Zero and oversize dimensions are clamped by the block.
		write_dims(4'd0, 4'd15, 4'd3);
		queue_random_items(PHASE_ITEMS);

		// Receiver holds off while the sender keeps offering transactions.
		write_dims(DIM_W'($urandom_range(2, 4)), DIM_W'($urandom_range(1, 4)),
			DIM_W'($urandom_range(2, 4)));
		push_item(FUNC_COMPUTE, 0, 0, '0);
		queue_random_items(PHASE_ITEMS);
		hold_requests++;

		// Sender pauses mid-phase until every outstanding result is back.
		write_dims(pick_dim(), pick_dim(), pick_dim());
		queue_random_items(PHASE_ITEMS / 2);
		drain_all();
		queue_random_items(PHASE_ITEMS / 2);

		repeat (7) begin
			write_dims(pick_dim(), pick_dim(), pick_dim());
			queue_random_items(PHASE_ITEMS);
		end

		write_dims(4'd15, 4'd0, 4'd15);
		quiet_tail = 1'b1;
		queue_random_items(PHASE_ITEMS);
		write_dims(pick_dim(), pick_dim(), pick_dim());
		queue_random_items(PHASE_ITEMS);

		drain_all();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("matrix_multiply_engine_tb: clean");
		else
			$display("matrix_multiply_engine_tb: errors");
		$finish;
	end

endmodule

[filelist.f]
rtl/mme_pkg.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine.sv
sim/matrix_multiply_engine_tb.sv
